>>> rtl/plsb_pkg.sv
// Package for the planet line segment builder: payload types, scale tables and sizes.
package plsb_pkg;

  // Segments per latitude line and the index width that addresses them
  localparam int SEG_COUNT = 32;
  localparam int SEG_IDX_W = 5;

  // Segment store entry: colour over limit
  localparam int SEG_ENTRY_W = 12;

  // Configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 9;
  localparam logic [CFG_INDEX_W-1:0] REG_START_LONGITUDE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BITMAP_WIDTH    = 1'd1;

  localparam logic [8:0] BITMAP_WIDTH_RESET = 9'd342;

  // Input transaction
  typedef struct packed {
    logic [6:0]  latitude;
    logic [15:0] picture_word;
  } in_t;

  // Output transaction: one merged run
  typedef struct packed {
    logic [3:0] run_color;
    logic [7:0] run_end_x;
    logic [7:0] line_start_x;
    logic       last_run;
  } out_t;

  // Latitude scale, indexed by line number
  localparam logic [7:0] LAT_SCALE [128] = '{
    8'h25,8'h3A,8'h4A,8'h55,8'h5F,8'h6A,8'h75,8'h7A,8'h80,8'h8A,8'h8F,8'h95,8'h9A,8'hA0,8'hA5,8'hAA,
    8'hB0,8'hB5,8'hB5,8'hBA,8'hC0,8'hC0,8'hC5,8'hCA,8'hCA,8'hCF,8'hCF,8'hD5,8'hD5,8'hDA,8'hDA,8'hDF,
    8'hDF,8'hE5,8'hE5,8'hE5,8'hEA,8'hEA,8'hEA,8'hEF,8'hEF,8'hEF,8'hEF,8'hF5,8'hF5,8'hF5,8'hF5,8'hFA,
    8'hFA,8'hFA,8'hFA,8'hFA,8'hFA,8'hFA,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,
    8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFA,8'hFA,8'hFA,8'hFA,8'hFA,8'hFA,
    8'hFA,8'hF5,8'hF5,8'hF5,8'hF5,8'hEF,8'hEF,8'hEF,8'hEF,8'hEA,8'hEA,8'hEA,8'hE5,8'hE5,8'hE5,8'hDF,
    8'hDF,8'hDA,8'hDA,8'hD5,8'hD5,8'hCF,8'hCF,8'hCA,8'hCA,8'hC5,8'hC0,8'hC0,8'hBA,8'hB5,8'hB5,8'hB0,
    8'hAA,8'hA5,8'hA0,8'h9A,8'h95,8'h8F,8'h8A,8'h80,8'h7A,8'h75,8'h6A,8'h5F,8'h55,8'h4A,8'h3A,8'h25
  };

  // Longitude scale, indexed by the half-step longitude
  localparam logic [7:0] LON_SCALE [256] = '{
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h01,8'h01,8'h01,8'h01,8'h01,8'h02,8'h02,8'h02,8'h02,8'h03,
    8'h03,8'h03,8'h04,8'h04,8'h05,8'h05,8'h05,8'h06,8'h06,8'h07,8'h07,8'h08,8'h08,8'h09,8'h09,8'h0A,
    8'h0A,8'h0B,8'h0B,8'h0C,8'h0C,8'h0D,8'h0E,8'h0E,8'h0F,8'h10,8'h10,8'h11,8'h12,8'h12,8'h13,8'h14,
    8'h15,8'h15,8'h16,8'h17,8'h18,8'h19,8'h19,8'h1A,8'h1B,8'h1C,8'h1D,8'h1E,8'h1F,8'h1F,8'h20,8'h21,
    8'h22,8'h23,8'h24,8'h25,8'h26,8'h27,8'h28,8'h29,8'h2A,8'h2B,8'h2C,8'h2D,8'h2E,8'h2F,8'h30,8'h31,
    8'h32,8'h33,8'h34,8'h35,8'h37,8'h38,8'h39,8'h3A,8'h3B,8'h3C,8'h3D,8'h3E,8'h40,8'h41,8'h42,8'h43,
    8'h44,8'h45,8'h46,8'h48,8'h49,8'h4A,8'h4B,8'h4C,8'h4E,8'h4F,8'h50,8'h51,8'h52,8'h54,8'h55,8'h56,
    8'h57,8'h58,8'h5A,8'h5B,8'h5C,8'h5D,8'h5F,8'h60,8'h61,8'h62,8'h63,8'h65,8'h66,8'h67,8'h68,8'h6A,
    8'h6B,8'h6C,8'h6D,8'h6F,8'h70,8'h71,8'h72,8'h73,8'h75,8'h76,8'h77,8'h78,8'h79,8'h7B,8'h7C,8'h7D,
    8'h7E,8'h7F,8'h81,8'h82,8'h83,8'h84,8'h85,8'h86,8'h87,8'h89,8'h8A,8'h8B,8'h8C,8'h8D,8'h8E,8'h8F,
    8'h90,8'h92,8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9A,8'h9B,8'h9C,8'h9D,8'h9E,8'h9F,8'hA0,
    8'hA1,8'hA2,8'hA3,8'hA4,8'hA5,8'hA6,8'hA7,8'hA8,8'hA8,8'hA9,8'hAA,8'hAB,8'hAC,8'hAD,8'hAE,8'hAE,
    8'hAF,8'hB0,8'hB1,8'hB2,8'hB2,8'hB3,8'hB4,8'hB5,8'hB5,8'hB6,8'hB7,8'hB7,8'hB8,8'hB9,8'hB9,8'hBA,
    8'hBB,8'hBB,8'hBC,8'hBC,8'hBD,8'hBD,8'hBE,8'hBE,8'hBF,8'hBF,8'hC0,8'hC0,8'hC1,8'hC1,8'hC2,8'hC2,
    8'hC2,8'hC3,8'hC3,8'hC4,8'hC4,8'hC4,8'hC5,8'hC5,8'hC5,8'hC5,8'hC6,8'hC6,8'hC6,8'hC6,8'hC6,8'hC7,
    8'hC7,8'hC7,8'hC7,8'hC7,8'hC7,8'hC7,8'hC7,8'hC7,8'hC7,8'hC7,8'hC7,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF
  };

endpackage

>>> rtl/plsb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module plsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/plsb_mac.sv
// Shared multiply-add unit: p = a * b + c, used for every product of the block.
module plsb_mac (
  input  logic [8:0]  a,
  input  logic [7:0]  b,
  input  logic [7:0]  c,
  output logic [16:0] p
);

  // Full-width product plus addend; the operand ranges keep it within 17 bits
  assign p = 17'(a) * 17'(b) + 17'(c);

endmodule

>>> rtl/planet_line_segment_builder.sv
// Top level of the planet line segment builder: sequencer, segment store and run output.
//
// The block takes 32 picture words per latitude line. For each word it does the table
// lookups on acceptance, then the scaling product on the shared multiply-add unit, which
// writes the segment store. After the 32nd word the same unit computes the line width
// and then the line start, then the merge walk reads the segment store one entry every
// cycle while it extends a run, with an open step before each run, and reads again the
// entry that ends a run at a colour change, emitting up to 32 runs with the last one
// flagged. in_ready is low from the acceptance of a word until its segment is stored,
// and through the whole walk of a line. A run waits in the output register while
// out_ready is low; the walk holds before closing the next run until it is taken.
module planet_line_segment_builder (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  plsb_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output plsb_pkg::out_t                    out_data,
  input  logic                              cfg_we,
  input  logic [plsb_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [plsb_pkg::CFG_DATA_W-1:0]   cfg_data
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MUL   = 6'b000010,
    ST_WIDTH = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_RUN   = 6'b010000,
    ST_FETCH = 6'b100000
  } state_t;

  localparam logic [plsb_pkg::SEG_IDX_W-1:0] LAST_SEG = plsb_pkg::SEG_IDX_W'(plsb_pkg::SEG_COUNT - 1);
  localparam logic [7:0] ROUND_HALF  = 8'h80;
  localparam logic [7:0] WIDTH_SCALE = 8'hc0;
  // 171 / 1024 approximates 1/6 exactly over the range of (width_max + 1) * 2
  localparam logic [7:0] SIXTH_RECIP = 8'd171;

  localparam logic [plsb_pkg::CFG_INDEX_W-1:0] REG_START_LONGITUDE_C =
    plsb_pkg::REG_START_LONGITUDE;
  localparam logic [plsb_pkg::CFG_INDEX_W-1:0] REG_BITMAP_WIDTH_C =
    plsb_pkg::REG_BITMAP_WIDTH;

  state_t state, state_next;

  // Configuration registers
  logic [7:0] start_longitude;
  logic [8:0] bitmap_width;

  // Per-word registers
  logic [7:0] lts;
  logic [7:0] lgs;
  logic [3:0] color_q;
  logic       wrap_q;
  logic [plsb_pkg::SEG_IDX_W-1:0] word_count;
  logic [plsb_pkg::SEG_IDX_W-1:0] first;
  logic       found;

  // Line and walk registers
  logic [7:0] wmax;
  logic [7:0] start_x;
  logic [plsb_pkg::SEG_IDX_W-1:0] seg;
  logic [plsb_pkg::SEG_IDX_W-1:0] run_count;
  logic [3:0] cc;
  logic [7:0] x;
  logic       new_run;

  // Shared unit operands
  logic [8:0]  mac_a;
  logic [7:0]  mac_b;
  logic [7:0]  mac_c;
  logic [16:0] mac_p;

  // Segment store
  logic                                ram_we;
  logic [plsb_pkg::SEG_IDX_W-1:0]      ram_raddr;
  logic [plsb_pkg::SEG_ENTRY_W-1:0]    ram_wdata;
  logic [plsb_pkg::SEG_ENTRY_W-1:0]    ram_rdata;

  // Input decode
  logic       lo_bit;
  logic [8:0] lon_sum;
  logic       lon_wrap;
  logic [7:0] lon_idx;
  logic [7:0] lgs_in;

  // Walk decode
  logic [3:0] ent_color;
  logic [7:0] ent_limit;
  logic       ent_match;
  logic [3:0] cc_use;
  logic [plsb_pkg::SEG_IDX_W-1:0] seg_inc;
  logic       run_end;
  logic [3:0] end_color;
  logic [7:0] end_x;
  logic [plsb_pkg::SEG_IDX_W-1:0] end_seg;
  logic       end_last;
  logic       can_emit;

  logic [7:0] width_raw;
  logic [8:0] twice_w;

  assign in_ready = (state == ST_IDLE);
  assign can_emit = !out_valid || out_ready;

  // Longitude sum and scale lookup for the incoming word
  always_comb begin
    lo_bit   = in_data.picture_word[15];
    lon_sum  = 9'(start_longitude) + 9'(in_data.picture_word[7:0]) + 9'(lo_bit);
    lon_wrap = lon_sum[8];
    lon_idx  = {lon_sum[6:0], ~(lo_bit | lon_wrap)};
    lgs_in   = lon_sum[7] ? 8'hff : plsb_pkg::LON_SCALE[lon_idx];
  end

  // Select shared unit operands by step
  always_comb begin
    mac_a = {1'b0, lts};
    mac_b = lgs;
    mac_c = ROUND_HALF;
    twice_w = {wmax + 8'd1, 1'b0};
    unique case (state)
      ST_WIDTH: begin
        mac_b = WIDTH_SCALE;
        mac_c = 8'd0;
      end
      ST_DIV: begin
        mac_a = twice_w;
        mac_b = SIXTH_RECIP;
        mac_c = 8'd0;
      end
      default: begin
      end
    endcase
  end

  plsb_mac u_mac (
    .a (mac_a),
    .b (mac_b),
    .c (mac_c),
    .p (mac_p)
  );

  assign ram_we    = (state == ST_MUL);
  assign ram_wdata = {color_q, mac_p[15:8]};
  assign width_raw = mac_p[15:8];

  plsb_ram #(
    .WIDTH (plsb_pkg::SEG_ENTRY_W),
    .DEPTH (plsb_pkg::SEG_COUNT)
  ) u_seg_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (word_count),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Decide how the walk advances on the entry just read
  always_comb begin
    ent_color = ram_rdata[11:8];
    ent_limit = ram_rdata[7:0];
    ent_match = new_run || (ent_color == cc);
    cc_use    = new_run ? ent_color : cc;
    seg_inc   = seg + plsb_pkg::SEG_IDX_W'(1);
    run_end   = 1'b0;
    end_color = cc;
    end_x     = x;
    end_seg   = seg;
    if (ent_match) begin
      end_color = cc_use;
      end_x     = ent_limit;
      end_seg   = seg_inc;
      run_end   = (seg_inc == first);
    end else begin
      run_end   = 1'b1;
    end
    end_last  = (run_count == LAST_SEG) || (end_x > wmax);
    ram_raddr = seg;
    if (state == ST_FETCH && ent_match && !run_end) begin
      ram_raddr = seg_inc;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_MUL;
      ST_MUL:   state_next = (word_count == LAST_SEG) ? ST_WIDTH : ST_IDLE;
      ST_WIDTH: state_next = ST_DIV;
      ST_DIV:   state_next = ST_RUN;
      ST_RUN:   state_next = ST_FETCH;
      ST_FETCH: begin
        if (run_end && can_emit) begin
          state_next = end_last ? ST_IDLE : ST_RUN;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      start_longitude <= 8'd0;
      bitmap_width    <= plsb_pkg::BITMAP_WIDTH_RESET;
      word_count      <= '0;
      found           <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_START_LONGITUDE_C: start_longitude <= cfg_data[7:0];
          REG_BITMAP_WIDTH_C:    bitmap_width    <= cfg_data;
          default: begin
          end
        endcase
      end
      if (state == ST_MUL) begin
        word_count <= word_count + plsb_pkg::SEG_IDX_W'(1);
        found      <= (word_count == '0) ? wrap_q : (found | wrap_q);
      end
      // Load a closed run, else drop the one just taken
      if (state == ST_FETCH && run_end && can_emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        // Capture the scales, colour and wrap flag of the accepted word
        if (in_valid) begin
          lts     <= plsb_pkg::LAT_SCALE[in_data.latitude];
          lgs     <= lgs_in;
          color_q <= in_data.picture_word[11:8];
          wrap_q  <= lon_wrap;
        end
      end
      ST_MUL: begin
        // Track the first wrapped segment of the line
        if (wrap_q && (!found || word_count == '0)) begin
          first <= word_count;
        end
      end
      ST_WIDTH: begin
        // Round the line width up to even; horizon defaults to the last segment
        wmax <= width_raw + {7'd0, width_raw[0]};
        if (!found) begin
          first <= LAST_SEG;
        end
      end
      ST_DIV: begin
        start_x   <= bitmap_width[8:1] - {1'b0, mac_p[16:10]};
        seg       <= first;
        run_count <= '0;
        new_run   <= 1'b1;
      end
      ST_RUN: begin
      end
      ST_FETCH: begin
        if (ent_match && !run_end) begin
          // Extend the run over this segment
          cc      <= cc_use;
          x       <= ent_limit;
          seg     <= seg_inc;
          new_run <= 1'b0;
        end else if (run_end && can_emit) begin
          // Close the run into the output register
          out_data.run_color    <= end_color;
          out_data.run_end_x    <= (end_x > wmax) ? wmax : end_x;
          out_data.line_start_x <= start_x;
          out_data.last_run     <= end_last;
          run_count             <= run_count + plsb_pkg::SEG_IDX_W'(1);
          seg                   <= end_seg;
          new_run               <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> sim/planet_line_segment_builder_test.sv
// Self-checking testbench for planet_line_segment_builder: directed lines, random lines, scoreboard.
`timescale 1ns / 1ps

module planet_line_segment_builder_test;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_TICKS = 16;
  localparam int HOLD_TICKS   = 300;
  localparam int TAIL_TICKS   = 64;

  // Latitude gain, indexed by line number
  localparam logic [7:0] LAT_GAIN [128] = '{
    'h25,'h3A,'h4A,'h55,'h5F,'h6A,'h75,'h7A,'h80,'h8A,'h8F,'h95,'h9A,'hA0,'hA5,'hAA,
    'hB0,'hB5,'hB5,'hBA,'hC0,'hC0,'hC5,'hCA,'hCA,'hCF,'hCF,'hD5,'hD5,'hDA,'hDA,'hDF,
    'hDF,'hE5,'hE5,'hE5,'hEA,'hEA,'hEA,'hEF,'hEF,'hEF,'hEF,'hF5,'hF5,'hF5,'hF5,'hFA,
    'hFA,'hFA,'hFA,'hFA,'hFA,'hFA,'hFF,'hFF,'hFF,'hFF,'hFF,'hFF,'hFF,'hFF,'hFF,'hFF,
    'hFF,'hFF,'hFF,'hFF,'hFF,'hFF,'hFF,'hFF,'hFF,'hFF,'hFA,'hFA,'hFA,'hFA,'hFA,'hFA,
    'hFA,'hF5,'hF5,'hF5,'hF5,'hEF,'hEF,'hEF,'hEF,'hEA,'hEA,'hEA,'hE5,'hE5,'hE5,'hDF,
    'hDF,'hDA,'hDA,'hD5,'hD5,'hCF,'hCF,'hCA,'hCA,'hC5,'hC0,'hC0,'hBA,'hB5,'hB5,'hB0,
    'hAA,'hA5,'hA0,'h9A,'h95,'h8F,'h8A,'h80,'h7A,'h75,'h6A,'h5F,'h55,'h4A,'h3A,'h25
  };

  // Longitude gain, indexed by the half-step longitude
  localparam logic [7:0] LON_GAIN [256] = '{
    'h00,'h00,'h00,'h00,'h00,'h00,'h01,'h01,'h01,'h01,'h01,'h02,'h02,'h02,'h02,'h03,
    'h03,'h03,'h04,'h04,'h05,'h05,'h05,'h06,'h06,'h07,'h07,'h08,'h08,'h09,'h09,'h0A,
    'h0A,'h0B,'h0B,'h0C,'h0C,'h0D,'h0E,'h0E,'h0F,'h10,'h10,'h11,'h12,'h12,'h13,'h14,
    'h15,'h15,'h16,'h17,'h18,'h19,'h19,'h1A,'h1B,'h1C,'h1D,'h1E,'h1F,'h1F,'h20,'h21,
    'h22,'h23,'h24,'h25,'h26,'h27,'h28,'h29,'h2A,'h2B,'h2C,'h2D,'h2E,'h2F,'h30,'h31,
    'h32,'h33,'h34,'h35,'h37,'h38,'h39,'h3A,'h3B,'h3C,'h3D,'h3E,'h40,'h41,'h42,'h43,
    'h44,'h45,'h46,'h48,'h49,'h4A,'h4B,'h4C,'h4E,'h4F,'h50,'h51,'h52,'h54,'h55,'h56,
    'h57,'h58,'h5A,'h5B,'h5C,'h5D,'h5F,'h60,'h61,'h62,'h63,'h65,'h66,'h67,'h68,'h6A,
    'h6B,'h6C,'h6D,'h6F,'h70,'h71,'h72,'h73,'h75,'h76,'h77,'h78,'h79,'h7B,'h7C,'h7D,
    'h7E,'h7F,'h81,'h82,'h83,'h84,'h85,'h86,'h87,'h89,'h8A,'h8B,'h8C,'h8D,'h8E,'h8F,
    'h90,'h92,'h93,'h94,'h95,'h96,'h97,'h98,'h99,'h9A,'h9B,'h9C,'h9D,'h9E,'h9F,'hA0,
    'hA1,'hA2,'hA3,'hA4,'hA5,'hA6,'hA7,'hA8,'hA8,'hA9,'hAA,'hAB,'hAC,'hAD,'hAE,'hAE,
    'hAF,'hB0,'hB1,'hB2,'hB2,'hB3,'hB4,'hB5,'hB5,'hB6,'hB7,'hB7,'hB8,'hB9,'hB9,'hBA,
    'hBB,'hBB,'hBC,'hBC,'hBD,'hBD,'hBE,'hBE,'hBF,'hBF,'hC0,'hC0,'hC1,'hC1,'hC2,'hC2,
    'hC2,'hC3,'hC3,'hC4,'hC4,'hC4,'hC5,'hC5,'hC5,'hC5,'hC6,'hC6,'hC6,'hC6,'hC6,'hC7,
    'hC7,'hC7,'hC7,'hC7,'hC7,'hC7,'hC7,'hC7,'hC7,'hC7,'hC7,'hFF,'hFF,'hFF,'hFF,'hFF
  };

  // How the 32 words of a directed line are derived from its base word
  typedef enum logic [1:0] {PAT_FLAT, PAT_STRIPE, PAT_ALT, PAT_RAMP} line_pattern_t;

  typedef struct packed {
    logic           set_cfg;
    logic [7:0]     slon;
    logic [8:0]     width;
    logic [6:0]     lat;
    logic [6:0]     lat_end;
    logic [15:0]    word;
    line_pattern_t  pat;
    logic           wrap_on;
    logic [4:0]     wrap_slot;
    logic           typed;
    plsb_pkg::out_t want;
  } line_case_t;

  localparam int NUM_CASES = 6;
  localparam line_case_t LINE_CASES [NUM_CASES] = '{
    // reset registers, saturated longitude on the widest line: one clipped run
    '{1'b0, 8'h00, 9'd0, 7'd63, 7'd63, 16'h0F80, PAT_FLAT, 1'b0, 5'd0, 1'b1,
      '{4'hF, 8'd192, 8'd107, 1'b1}},
    // zero width and longitude on the narrowest line: full laps until 32 runs
    '{1'b1, 8'h00, 9'd0, 7'd0, 7'd0, 16'h0000, PAT_FLAT, 1'b0, 5'd0, 1'b0, '0},
    // top registers, every word wraps, colour flips on each word
    '{1'b1, 8'hFF, 9'd511, 7'd127, 7'd63, 16'h8000, PAT_ALT, 1'b0, 5'd0, 1'b0, '0},
    // mixed latitudes, colour stripes, horizon in mid line
    '{1'b1, 8'h00, 9'd342, 7'd20, 7'd100, 16'h0340, PAT_STRIPE, 1'b1, 5'd7, 1'b0, '0},
    // longitude ramp with offset, horizon late in the line
    '{1'b1, 8'h40, 9'd200, 7'd10, 7'd127, 16'h8500, PAT_RAMP, 1'b1, 5'd20, 1'b0, '0},
    // all ones, tiny width so the line start underflows
    '{1'b1, 8'h01, 9'd1, 7'd127, 7'd0, 16'hFFFF, PAT_FLAT, 1'b1, 5'd0, 1'b0, '0}
  };

  logic                             clk;
  logic                             rst       = 1'b1;
  logic                             in_valid  = 1'b0;
  logic                             in_ready;
  plsb_pkg::in_t                    in_data   = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  plsb_pkg::out_t                   out_data;
  logic                             cfg_we    = 1'b0;
  logic [plsb_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [plsb_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          squeeze_go    = 1'b0;
  bit          squeeze_done  = 1'b0;
  int          errors        = 0;
  int          cycles        = 0;

  // Predicted line state and the runs still owed by the block
  plsb_pkg::out_t runs_due [$];
  plsb_pkg::out_t want_run;
  logic [7:0] seg_end  [32];
  logic [3:0] seg_hue  [32];
  bit         seg_wrap [32];
  logic [4:0] word_slot    = 5'd0;
  logic [7:0] lon_offset   = 8'd0;
  logic [8:0] bitmap_width = 9'd342;

  planet_line_segment_builder dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  task automatic flag_error(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) flag_error($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // Scale one word and record it in the current slot
  function automatic void store_segment(input logic [6:0] lat, input logic [15:0] w);
    int gain, lsb, sum, lgain, idx;
    bit wr;
    gain = int'(LAT_GAIN[lat]);
    lsb  = int'(w[15]);
    sum  = int'(lon_offset) + int'(w[7:0]) + lsb;
    wr   = ((sum >> 8) & 1) != 0;
    if ((sum & 'h80) != 0) begin
      lgain = 'hff;
    end else begin
      idx   = ((sum & 'h7f) << 1) + ((lsb != 0 || wr) ? 0 : 1);
      lgain = int'(LON_GAIN[idx]);
    end
    seg_end[word_slot]  = 8'((gain * lgain + 'h80) >> 8);
    seg_hue[word_slot]  = w[11:8];
    seg_wrap[word_slot] = wr;
  endfunction

  // Walk the line from the western horizon and queue the merged runs
  function automatic void walk_line(input logic [6:0] lat);
    int gain, wmax, sx, s, first, n, x;
    logic [3:0] hue;
    bit stop;
    plsb_pkg::out_t r;
    gain = int'(LAT_GAIN[lat]);
    wmax = (gain * 192) >> 8;
    if (wmax % 2 == 1) wmax = wmax + 1;
    sx = (int'(bitmap_width) / 2 - ((wmax + 1) * 2) / 6) & 'hff;
    s = 0;
    while (s < 32 && !seg_wrap[s]) s++;
    if (s >= 32) s = 31;
    first = s;
    n = 0;
    stop = 1'b0;
    while (!stop) begin
      hue = seg_hue[s];
      x = 0;
      while (seg_hue[s] == hue) begin
        x = int'(seg_end[s]);
        s = (s + 1) % 32;
        if (s == first) break;
      end
      n++;
      stop = (n >= 32) || (x > wmax);
      r.run_color    = hue;
      r.run_end_x    = 8'((x > wmax) ? wmax : x);
      r.line_start_x = 8'(sx);
      r.last_run     = stop;
      runs_due.push_back(r);
    end
  endfunction

  function automatic logic [15:0] case_word(input line_case_t lc, input int i);
    logic [15:0] w;
    logic [4:0]  k;
    k = 5'(i);
    w = lc.word;
    case (lc.pat)
      PAT_STRIPE: w[11:8] = lc.word[11:8] + 4'(k >> 2);
      PAT_ALT:    w[11:8] = lc.word[11:8] ^ {4{k[0]}};
      PAT_RAMP: begin
        w[7:0]  = lc.word[7:0] + {k, 3'b000};
        w[11:8] = lc.word[11:8] + 4'(k >> 3);
      end
      default: ;
    endcase
    if (lc.wrap_on && k == lc.wrap_slot) w = {1'b1, w[14:8], 8'hff};
    return w;
  endfunction

  // Offer one word, hold it until taken, then advance the prediction
  task automatic put_word(input logic [6:0] lat, input logic [15:0] w,
                          input bit typed, input plsb_pkg::out_t want);
    int depth;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {lat, w};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    store_segment(lat, w);
    if (word_slot == 5'd31) begin
      depth = runs_due.size();
      walk_line(lat);
      if (typed) begin
        while (runs_due.size() > depth) void'(runs_due.pop_back());
        runs_due.push_back(want);
      end
    end
    word_slot = word_slot + 5'd1;
  endtask

  // Drop valid, let every owed run arrive, then let the block settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (runs_due.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] slon, input logic [8:0] width);
    cfg_we    <= 1'b1;
    cfg_index <= plsb_pkg::REG_START_LONGITUDE;
    cfg_data  <= {1'b0, slon};
    @(posedge clk);
    lon_offset = slon;
    cfg_index <= plsb_pkg::REG_BITMAP_WIDTH;
    cfg_data  <= width;
    @(posedge clk);
    bitmap_width = width;
    cfg_we <= 1'b0;
  endtask

  // Receiver: random ready, plus one long hold-off on request
  initial begin : sink_side
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (squeeze_go && !squeeze_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_TICKS) @(posedge clk);
        squeeze_done = 1'b1;
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      @(posedge clk);
    end
  end

  // Compare each accepted run with the oldest owed one
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (runs_due.size() == 0) begin
        flag_error($sformatf("run %h with nothing owed", out_data));
      end else begin
        want_run = runs_due.pop_front();
        check_field("run_color", 8'(out_data.run_color), 8'(want_run.run_color));
        check_field("run_end_x", out_data.run_end_x, want_run.run_end_x);
        check_field("line_start_x", out_data.line_start_x, want_run.line_start_x);
        check_field("last_run", 8'(out_data.last_run), 8'(want_run.last_run));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("planet_line_segment_builder regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    line_case_t  lc;
    int          len;
    logic [6:0]  lat;
    logic [6:0]  line_lat;
    logic [15:0] w;
    logic [3:0]  hue_a;
    logic [3:0]  hue_b;
    logic [3:0]  cur_hue;
    logic [7:0]  lon_acc;
    logic [7:0]  slon;
    logic [8:0]  width;
    line_lat = '0;
    hue_a    = '0;
    hue_b    = '0;
    cur_hue  = '0;
    lon_acc  = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed lines, first one on reset register values
    send_idle_pct = 15;
    recv_idle_pct = 48;
    for (int c = 0; c < NUM_CASES; c++) begin
      lc = LINE_CASES[c];
      if (lc.set_cfg) begin
        wait_drained();
        set_config(lc.slon, lc.width);
      end
      for (int i = 0; i < 32; i++) begin
        put_word((i == 31) ? lc.lat_end : lc.lat, case_word(lc, i), lc.typed, lc.want);
      end
    end

    // Random phases; boundaries fall anywhere in a line
    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      if (ph < 2) begin
        send_idle_pct = 15;
        recv_idle_pct = 48;
      end else if (ph < 4) begin
        send_idle_pct = 48;
        recv_idle_pct = 15;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      slon  = ($urandom_range(0, 3) == 0) ? {8{1'($urandom_range(0, 1))}}
                                          : 8'($urandom_range(0, 255));
      width = ($urandom_range(0, 3) == 0) ? {9{1'($urandom_range(0, 1))}}
                                          : 9'($urandom_range(0, 511));
      set_config(slon, width);
      len = (ph == 4) ? 40 : $urandom_range(2, 6);
      if (ph == 4) squeeze_go = 1'b1;
      for (int i = 0; i < len; i++) begin
        // pick a fresh latitude, colour pair and longitude base per line
        if (word_slot == 5'd0) begin
          line_lat = 7'($urandom_range(0, 127));
          hue_a    = 4'($urandom_range(0, 15));
          hue_b    = 4'($urandom_range(0, 15));
          cur_hue  = hue_a;
          lon_acc  = 8'($urandom_range(0, 15));
        end
        if ($urandom_range(0, 99) < 15) begin
          lat = 7'($urandom_range(0, 127));
          w   = 16'($urandom);
        end else begin
          if ($urandom_range(0, 3) == 0) cur_hue = (cur_hue == hue_a) ? hue_b : hue_a;
          lon_acc = lon_acc + 8'($urandom_range(0, 12));
          lat = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127)) : line_lat;
          w   = {1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), cur_hue, lon_acc};
        end
        put_word(lat, w, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (TAIL_TICKS) @(posedge clk);
    if (runs_due.size() != 0) flag_error($sformatf("%0d runs never arrived", runs_due.size()));
    if (errors == 0) begin
      $display("planet_line_segment_builder regression: pass");
    end else begin
      $display("planet_line_segment_builder regression: fail");
    end
    $finish;
  end

endmodule

>>> planet_line_segment_builder.f
rtl/plsb_pkg.sv
rtl/plsb_ram.sv
rtl/plsb_mac.sv
rtl/planet_line_segment_builder.sv
sim/planet_line_segment_builder_test.sv
